// ===== src/dwpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwpd_pkg
// shared widths, register indexes and controller/datapath types
// ----------------------------------------------------------------------------
package dwpd_pkg;

  localparam int DT_W       = 20;
  localparam int POS_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int DUTY_W     = 8;
  localparam int FS_W       = 16;

  localparam int IN_TDATA_W  = 216;
  localparam int OUT_TDATA_W = 40;

  localparam int ERR_W  = POS_W + 1;
  localparam int DER_W  = 47;
  localparam int VOLT_W = 42;
  localparam int MA_W   = 48;
  localparam int MB_W   = 21;
  localparam int PROD_W = MA_W + MB_W;
  localparam int QUO_W  = ERR_W + DT_W;
  localparam int DIV_CNT_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_PROP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FEED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ILIM  = 3'd4;

  localparam logic [GAIN_W-1:0] PROP_RESET  = 16'd12800;
  localparam logic [GAIN_W-1:0] INT_RESET   = 16'd1280;
  localparam logic [GAIN_W-1:0] DERIV_RESET = 16'd1280;
  localparam logic [GAIN_W-1:0] FEED_RESET  = 16'd640;
  localparam logic [LIM_W-1:0]  ILIM_RESET  = 31'd26214;

  localparam logic [QUO_W-1:0] DERIV_CAP = {7'd0, {46{1'b1}}};
  localparam logic signed [PROD_W-1:0] VOLT_CAP = {28'd0, 1'b1, 40'd0};
  localparam logic [PROD_W-1:0] SAT_LIMIT = {36'd0, 8'd255, 25'd0};

  typedef enum logic [2:0] {
    MSEL_E_DT,
    MSEL_KP,
    MSEL_KI,
    MSEL_KD,
    MSEL_KF,
    MSEL_SCALE
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic     wheel;
    logic     load_in;
    logic     err_we;
    logic     div_start;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     integ_we;
    logic     deriv_we;
    logic     volt_we;
    logic     res_we;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== src/dwpd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwpd_dp
// datapath: config registers, wheel state, shared multiplier, divider, output
// ----------------------------------------------------------------------------
module dwpd_dp #(
  parameter int FULL_SCALE_DUTY = 255
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [dwpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dwpd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [dwpd_pkg::IN_TDATA_W-1:0] in_data,
  input  wire dwpd_pkg::dp_cmd_t               cmd,
  output dwpd_pkg::dp_status_t                 status,
  output logic [dwpd_pkg::OUT_TDATA_W-1:0]     out_data
);
  import dwpd_pkg::*;

  localparam logic [FS_W-1:0] FS = FS_W'(FULL_SCALE_DUTY);

  logic [GAIN_W-1:0] prop_gain, int_gain, deriv_gain, feed_gain;
  logic [LIM_W-1:0]  integral_limit;

  logic [DT_W-1:0]         dt;
  logic signed [POS_W-1:0] tgt [2];
  logic signed [POS_W-1:0] meas [2];
  logic signed [POS_W-1:0] vel [2];
  logic signed [POS_W-1:0] integ [2];
  logic signed [POS_W-1:0] prev [2];

  logic signed [ERR_W-1:0]  err;
  logic signed [DER_W-1:0]  deriv;
  logic signed [VOLT_W-1:0] volt;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] acc;

  logic                 div_neg;
  logic [QUO_W-1:0]     dq;
  logic [DT_W-1:0]      rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_busy;

  logic [DUTY_W-1:0] res_in1 [2];
  logic [DUTY_W-1:0] res_in2 [2];
  logic              res_sat [2];

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic [VOLT_W-2:0]        umag;
  logic signed [PROD_W-1:0] prod_bias;
  logic signed [48:0]       step;
  logic signed [49:0]       isum;
  logic signed [49:0]       lim_pos;
  logic signed [ERR_W-1:0]  diff;
  logic [ERR_W-1:0]         diff_mag;
  logic [DT_W:0]            trial;
  logic                     qbit;
  logic [QUO_W-1:0]         qc;
  logic                     sat;
  logic [DUTY_W-1:0]        duty;
  logic [DT_W-1:0]          dt_in;

  assign umag     = volt[VOLT_W-1] ? (VOLT_W-1)'(-volt) : volt[VOLT_W-2:0];
  assign prod_bias = prod[PROD_W-1] ? prod + PROD_W'(20'hFFFFF) : prod;
  assign step     = 49'(prod_bias >>> DT_W);
  assign isum     = 50'(integ[cmd.wheel]) + 50'(step);
  assign lim_pos  = 50'($unsigned(integral_limit));
  assign diff     = ERR_W'(meas[cmd.wheel]) - ERR_W'(prev[cmd.wheel]);
  assign diff_mag = diff[ERR_W-1] ? ERR_W'(-diff) : diff;
  assign trial    = {rem, dq[QUO_W-1]};
  assign qbit     = trial >= {1'b0, dt};
  assign qc       = (dq > DERIV_CAP) ? DERIV_CAP : dq;
  assign sat      = $unsigned(prod) > SAT_LIMIT;
  assign duty     = sat ? DUTY_W'(255) : prod[32:25];
  assign dt_in    = in_data[19:0];

  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_E_DT: begin
        mul_a = MA_W'(err);
        mul_b = MB_W'({1'b0, dt});
      end
      MSEL_KP: begin
        mul_a = MA_W'(err);
        mul_b = MB_W'({1'b0, prop_gain});
      end
      MSEL_KI: begin
        mul_a = MA_W'(integ[cmd.wheel]);
        mul_b = MB_W'({1'b0, int_gain});
      end
      MSEL_KD: begin
        mul_a = MA_W'(deriv);
        mul_b = MB_W'({1'b0, deriv_gain});
      end
      MSEL_KF: begin
        mul_a = MA_W'(vel[cmd.wheel]);
        mul_b = MB_W'({1'b0, feed_gain});
      end
      MSEL_SCALE: begin
        mul_a = MA_W'({1'b0, umag});
        mul_b = MB_W'({1'b0, FS});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= PROP_RESET;
      int_gain       <= INT_RESET;
      deriv_gain     <= DERIV_RESET;
      feed_gain      <= FEED_RESET;
      integral_limit <= ILIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP:  prop_gain      <= cfg_data[GAIN_W-1:0];
        REG_INT:   int_gain       <= cfg_data[GAIN_W-1:0];
        REG_DERIV: deriv_gain     <= cfg_data[GAIN_W-1:0];
        REG_FEED:  feed_gain      <= cfg_data[GAIN_W-1:0];
        REG_ILIM:  integral_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dt      <= (dt_in == '0) ? DT_W'(1) : dt_in;
      tgt[0]  <= in_data[51:20];
      meas[0] <= in_data[83:52];
      vel[0]  <= in_data[115:84];
      tgt[1]  <= in_data[147:116];
      meas[1] <= in_data[179:148];
      vel[1]  <= in_data[211:180];
    end
    if (cmd.err_we) begin
      err <= ERR_W'(tgt[cmd.wheel]) - ERR_W'(meas[cmd.wheel]);
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    unique case (cmd.acc_op)
      ACC_HOLD: ;
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= acc + prod;
      ACC_SUB:  acc <= acc - prod;
      default: ;
    endcase
    if (cmd.deriv_we) begin
      deriv <= div_neg ? -DER_W'(qc) : DER_W'(qc);
    end
    if (cmd.volt_we) begin
      if (acc > VOLT_CAP) begin
        volt <= VOLT_W'(VOLT_CAP);
      end else if (acc < -VOLT_CAP) begin
        volt <= VOLT_W'(-VOLT_CAP);
      end else begin
        volt <= VOLT_W'(acc);
      end
    end
    if (cmd.res_we) begin
      res_sat[cmd.wheel] <= sat;
      res_in1[cmd.wheel] <= (volt > 0) ? '0 : duty;
      res_in2[cmd.wheel] <= (volt > 0) ? duty : '0;
    end
    if (cmd.out_load) begin
      out_data <= {6'd0, res_sat[1], res_sat[0],
                   res_in2[1], res_in1[1], res_in2[0], res_in1[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ[0] <= '0;
      integ[1] <= '0;
      prev[0]  <= '0;
      prev[1]  <= '0;
    end else begin
      if (cmd.integ_we) begin
        if (isum > lim_pos) begin
          integ[cmd.wheel] <= POS_W'(lim_pos);
        end else if (isum < -lim_pos) begin
          integ[cmd.wheel] <= POS_W'(-lim_pos);
        end else begin
          integ[cmd.wheel] <= POS_W'(isum);
        end
      end
      if (cmd.deriv_we) begin
        prev[cmd.wheel] <= meas[cmd.wheel];
      end
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= DIV_CNT_W'(QUO_W);
      div_neg  <= diff[ERR_W-1];
      dq       <= {diff_mag, DT_W'(0)};
      rem      <= '0;
    end else if (div_busy) begin
      rem      <= qbit ? DT_W'(trial - {1'b0, dt}) : trial[DT_W-1:0];
      dq       <= {dq[QUO_W-2:0], qbit};
      div_cnt  <= div_cnt - DIV_CNT_W'(1);
      div_busy <= div_cnt != DIV_CNT_W'(1);
    end
  end

  assign status.div_busy = div_busy;

`ifndef SYNTH
  a_integ_clamped: assert property (@(posedge clk) disable iff (rst)
    (cmd.integ_we && !cfg_we) |=>
      (50'(integ[$past(cmd.wheel)]) <= lim_pos) && (50'(integ[$past(cmd.wheel)]) >= -lim_pos))
    else $error("integral outside clamp");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> div_busy && div_cnt == DIV_CNT_W'(QUO_W))
    else $error("divider did not start");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    !div_busy |-> div_cnt == '0)
    else $error("divider count left over");
`endif

endmodule
`default_nettype wire

// ===== src/dwpd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwpd_ctrl
// sequencer for the two wheel computations and the output handshake
// ----------------------------------------------------------------------------
module dwpd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire dwpd_pkg::dp_status_t status,
  output dwpd_pkg::dp_cmd_t         cmd
);
  import dwpd_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_ERR   = 15'b000000000000010,
    S_EDT   = 15'b000000000000100,
    S_INTEG = 15'b000000000001000,
    S_DIV   = 15'b000000000010000,
    S_DSAT  = 15'b000000000100000,
    S_KP    = 15'b000000001000000,
    S_KI    = 15'b000000010000000,
    S_KD    = 15'b000000100000000,
    S_KF    = 15'b000001000000000,
    S_SUM   = 15'b000010000000000,
    S_CLAMP = 15'b000100000000000,
    S_SCALE = 15'b001000000000000,
    S_RES   = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  state_t state, state_next;
  logic   wheel, wheel_next;
  logic   out_valid_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next     = state;
    wheel_next     = wheel;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.wheel      = wheel;
    cmd.mul_sel    = MSEL_E_DT;
    cmd.acc_op     = ACC_HOLD;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          wheel_next  = 1'b0;
          state_next  = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err_we    = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = S_EDT;
      end
      S_EDT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_E_DT;
        state_next  = S_INTEG;
      end
      S_INTEG: begin
        cmd.integ_we = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_DSAT;
        end
      end
      S_DSAT: begin
        cmd.deriv_we = 1'b1;
        state_next   = S_KP;
      end
      S_KP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_KP;
        state_next  = S_KI;
      end
      S_KI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_KI;
        cmd.acc_op  = ACC_LOAD;
        state_next  = S_KD;
      end
      S_KD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_KD;
        cmd.acc_op  = ACC_ADD;
        state_next  = S_KF;
      end
      S_KF: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_KF;
        cmd.acc_op  = ACC_SUB;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.acc_op = ACC_ADD;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.volt_we = 1'b1;
        state_next  = S_SCALE;
      end
      S_SCALE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_SCALE;
        state_next  = S_RES;
      end
      S_RES: begin
        cmd.res_we = 1'b1;
        if (!wheel) begin
          wheel_next = 1'b1;
          state_next = S_ERR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wheel     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wheel     <= wheel_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_ERR && !wheel)
    else $error("accept did not start left wheel");
  a_right_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_RES && !wheel) |=> state == S_ERR && wheel)
    else $error("right wheel not started");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid && state == S_IDLE)
    else $error("output load lost");
`endif

endmodule
`default_nettype wire

// ===== src/dual_wheel_pid_hbridge_drive.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_wheel_pid_hbridge_drive
// two-wheel position pid with feed-forward and h-bridge duty outputs
// ----------------------------------------------------------------------------
// usage: one transaction on s_axis carries the time step and, per wheel,
// target position, measured position and feed-forward velocity. one
// transaction on m_axis returns both bridges' duties and saturation flags.
// the cfg channel writes gains and the integral limit; the user must write
// them only while the block is idle, which the block does not enforce.
// cfg_ready is always high, unknown indexes are dropped.
// each item runs as two wheel passes between the accept state and the
// output load state. each pass runs a restoring divider for the
// derivative, then nine steps around the one shared 48x21 multiplier
// (six multiplies per wheel). one item is worked on at a time;
// s_axis_tready is high only while the sequencer is idle.
// a finished result sits in the output register; a new item is accepted
// while it waits, and the next result is held back until m_axis_tready
// takes the pending one.
// reset: synchronous, restores register defaults, clears both integrals and
// previous positions and drops any pending output.
// ----------------------------------------------------------------------------
module dual_wheel_pid_hbridge_drive #(
  parameter int FULL_SCALE_DUTY = 255
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // time_step, left_target_pos, left_measured_pos, left_feed_vel,
  // right_target_pos, right_measured_pos, right_feed_vel
  input  wire logic [dwpd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // left_in1_duty, left_in2_duty, right_in1_duty, right_in2_duty,
  // left_saturated, right_saturated
  output logic [dwpd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dwpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dwpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dwpd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  dwpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  dwpd_dp #(
    .FULL_SCALE_DUTY(FULL_SCALE_DUTY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_axis_tdata)
  );

`ifndef SYNTH
  a_left_one_side: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == '0) || (m_axis_tdata[15:8] == '0))
    else $error("left bridge driven both ways");
  a_right_one_side: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[23:16] == '0) || (m_axis_tdata[31:24] == '0))
    else $error("right bridge driven both ways");
  a_left_sat_full: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[32]) |->
      (m_axis_tdata[7:0] == 8'd255) || (m_axis_tdata[15:8] == 8'd255))
    else $error("left saturated without full duty");
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire
